// ===== hw/rtl/lfu_cache_table_unit_assert.svh =====
// Assertion macros used by the checker file of the cache table unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LFU_CACHE_TABLE_UNIT_ASSERT_SVH
`define LFU_CACHE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LFU_CTBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LFU_CTBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lfu_ctbl_pkg.sv =====
// Shared constants, types and width helpers for the LFU cache table unit.
// No dependencies; the interfaces, the store, the scan unit and the top level refer to it by scoped names.
`default_nettype none

package lfu_ctbl_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Write enables for the entry store; addresses and data travel alongside.
  typedef struct packed {
    logic key_we;
    logic data_we;
    logic count_we;
    logic rank_we;
  } store_wr_t;

  // Sequencer controls for the scan unit.
  typedef struct packed {
    logic clear;  // start of a new item: drop the accumulated results
    logic step;   // read data of one entry is present this cycle
    logic live;   // that entry holds a valid key
  } scan_ctl_t;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int occ_width(input int n);
    return $clog2(n + 1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lfu_ctbl_req_if.sv =====
// Request channel of the LFU cache table unit: operation, key and value.
// Depends on lfu_ctbl_pkg for the field widths.
`default_nettype none

interface lfu_ctbl_req_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [lfu_ctbl_pkg::KEY_W-1:0]   key;
  logic [lfu_ctbl_pkg::DATA_W-1:0]  value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfu_ctbl_rsp_if.sv =====
// Response channel of the LFU cache table unit: found, read_value and evicted.
// Depends on lfu_ctbl_pkg for the field widths.
`default_nettype none

interface lfu_ctbl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [lfu_ctbl_pkg::DATA_W-1:0]  read_value;
  logic                             evicted;

  modport source (output valid, output found, output read_value, output evicted, input ready);
  modport sink   (input valid, input found, input read_value, input evicted, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfu_ctbl_cfg_if.sv =====
// Configuration write channel of the LFU cache table unit (capacity register).
// Depends on lfu_ctbl_pkg for the register width.
`default_nettype none

interface lfu_ctbl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lfu_ctbl_pkg::CAP_W-1:0]  capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfu_ctbl_store.sv =====
// Entry store of the LFU cache table: key, data, use count and recency rank memories.
// One registered read port and one write port; depends on lfu_ctbl_pkg.
`default_nettype none

module lfu_ctbl_store #(
  parameter int ENTRIES    = lfu_ctbl_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_ctbl_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                            clk,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0]     rd_idx,
  output logic      [lfu_ctbl_pkg::KEY_W-1:0]                  rd_key,
  output logic      [lfu_ctbl_pkg::DATA_W-1:0]                 rd_data,
  output logic      [COUNT_BITS-1:0]                           rd_count,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0]     rd_rank,
  input  wire lfu_ctbl_pkg::store_wr_t                         wr,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0]     wr_idx,
  input  wire logic [lfu_ctbl_pkg::KEY_W-1:0]                  wr_key,
  input  wire logic [lfu_ctbl_pkg::DATA_W-1:0]                 wr_data,
  input  wire logic [COUNT_BITS-1:0]                           wr_count,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0]     wr_rank
);

  localparam int IDX_W = lfu_ctbl_pkg::idx_width(ENTRIES);

  logic [lfu_ctbl_pkg::KEY_W-1:0]  key_mem   [ENTRIES];
  logic [lfu_ctbl_pkg::DATA_W-1:0] data_mem  [ENTRIES];
  logic [COUNT_BITS-1:0]           count_mem [ENTRIES];
  logic [IDX_W-1:0]                rank_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr_idx] <= wr_key;
    end
    if (wr.data_we) begin
      data_mem[wr_idx] <= wr_data;
    end
    if (wr.count_we) begin
      count_mem[wr_idx] <= wr_count;
    end
    if (wr.rank_we) begin
      rank_mem[wr_idx] <= wr_rank;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_idx];
    rd_data  <= data_mem[rd_idx];
    rd_count <= count_mem[rd_idx];
    rd_rank  <= rank_mem[rd_idx];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_ctbl_scan.sv =====
// Shared scan unit: one entry per cycle it compares the key, tracks the victim
// (lowest count, then oldest), the first free slot and the occupancy.
// It also applies the recency update left by the previous item. Depends on lfu_ctbl_pkg.
`default_nettype none

module lfu_ctbl_scan #(
  parameter int ENTRIES    = lfu_ctbl_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_ctbl_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire lfu_ctbl_pkg::scan_ctl_t                     ctl,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] idx,
  input  wire logic [lfu_ctbl_pkg::KEY_W-1:0]              search_key,
  input  wire logic [lfu_ctbl_pkg::KEY_W-1:0]              ent_key,
  input  wire logic [lfu_ctbl_pkg::DATA_W-1:0]             ent_data,
  input  wire logic [COUNT_BITS-1:0]                       ent_count,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] ent_rank,
  input  wire logic                                        pend_on,
  input  wire logic                                        pend_all,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] pend_thresh,
  input  wire logic [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] pend_special,
  output logic                                             wb_en,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] wb_rank,
  output logic                                             hit,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] hit_idx,
  output logic      [lfu_ctbl_pkg::DATA_W-1:0]             hit_data,
  output logic      [COUNT_BITS-1:0]                       hit_count,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] hit_rank,
  output logic                                             vic_found,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] vic_idx,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] vic_rank,
  output logic                                             free_found,
  output logic      [lfu_ctbl_pkg::idx_width(ENTRIES)-1:0] free_idx,
  output logic      [lfu_ctbl_pkg::occ_width(ENTRIES)-1:0] occ
);

  localparam int IDX_W = lfu_ctbl_pkg::idx_width(ENTRIES);
  localparam int OCC_W = lfu_ctbl_pkg::occ_width(ENTRIES);

  logic [COUNT_BITS-1:0] vic_count;
  logic [IDX_W-1:0]      cur_rank;
  logic                  bump;
  logic                  better;

  // The stored rank still lacks the previous item's update; correct it on the fly.
  always_comb begin
    bump     = pend_on && (idx != pend_special) && (pend_all || (ent_rank < pend_thresh));
    cur_rank = bump ? ent_rank + 1'b1 : ent_rank;
    wb_en    = ctl.step && ctl.live && pend_on;
    wb_rank  = cur_rank;
    better   = !vic_found || (ent_count < vic_count) ||
               ((ent_count == vic_count) && (cur_rank > vic_rank));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hit        <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
      occ        <= '0;
    end else if (ctl.step) begin
      if (ctl.live) begin
        occ <= occ + OCC_W'(1);
        if (!hit && (ent_key == search_key)) begin
          hit       <= 1'b1;
          hit_idx   <= idx;
          hit_data  <= ent_data;
          hit_count <= ent_count;
          hit_rank  <= cur_rank;
        end
        if (better) begin
          vic_found <= 1'b1;
          vic_idx   <= idx;
          vic_count <= ent_count;
          vic_rank  <= cur_rank;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_cache_table_unit.sv =====
// Top level of the LFU cache table: sequencer, valid bits, capacity register, result register.
// Instantiates lfu_ctbl_store and lfu_ctbl_scan; depends on lfu_ctbl_pkg and the channel interfaces.
`default_nettype none

// Key-value cache of ENTRIES entries with least-frequently-used replacement, ties going to
// the least recently used entry. Each request is a get or a put and gives exactly one
// response. The entry memories are scanned once per request through
// their single read port, one entry per cycle; then a tail state and a finishing state settle and
// commit the result. The unit takes no new request
// while one is in flight, but a finished response may wait in its output register while
// the next request is accepted and scanned. If that response has still not been taken when
// the next scan ends, the unit waits in its commit cycle until it has been. Recency updates
// left by one request are applied during the scan of the next. The capacity register may
// only be written while idle.
module lfu_cache_table_unit #(
  parameter int ENTRIES    = lfu_ctbl_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_ctbl_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  lfu_ctbl_req_if.sink    req,
  lfu_ctbl_rsp_if.source  rsp,
  lfu_ctbl_cfg_if.sink    cfg
);

  localparam int IDX_W = lfu_ctbl_pkg::idx_width(ENTRIES);
  localparam int OCC_W = lfu_ctbl_pkg::occ_width(ENTRIES);
  localparam int CAP_W = lfu_ctbl_pkg::CAP_W;
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                        state;
  logic [CAP_W-1:0]                  capacity;
  logic                              op_r;
  logic [lfu_ctbl_pkg::KEY_W-1:0]    key_r;
  logic [lfu_ctbl_pkg::DATA_W-1:0]   val_r;
  logic [IDX_W-1:0]                  scan_idx;
  logic                              s1_step;
  logic [IDX_W-1:0]                  s1_idx;
  logic [ENTRIES-1:0]                valid_bits;
  logic [ENTRIES-1:0]                valid_next;

  logic                              pend_on;
  logic                              pend_all;
  logic [IDX_W-1:0]                  pend_thresh;
  logic [IDX_W-1:0]                  pend_special;

  logic                              rsp_valid;
  logic                              rsp_found;
  logic [lfu_ctbl_pkg::DATA_W-1:0]   rsp_read_value;
  logic                              rsp_evicted;

  logic [lfu_ctbl_pkg::KEY_W-1:0]    ent_key;
  logic [lfu_ctbl_pkg::DATA_W-1:0]   ent_data;
  logic [COUNT_BITS-1:0]             ent_count;
  logic [IDX_W-1:0]                  ent_rank;

  lfu_ctbl_pkg::store_wr_t           wr;
  logic [IDX_W-1:0]                  wr_idx;
  logic [COUNT_BITS-1:0]             wr_count;
  logic [IDX_W-1:0]                  wr_rank;

  lfu_ctbl_pkg::scan_ctl_t           scan_ctl;
  logic                              wb_en;
  logic [IDX_W-1:0]                  wb_rank;
  logic                              hit;
  logic [IDX_W-1:0]                  hit_idx;
  logic [lfu_ctbl_pkg::DATA_W-1:0]   hit_data;
  logic [COUNT_BITS-1:0]             hit_count;
  logic [IDX_W-1:0]                  hit_rank;
  logic                              vic_found;
  logic [IDX_W-1:0]                  vic_idx;
  logic [IDX_W-1:0]                  vic_rank;
  logic                              free_found;
  logic [IDX_W-1:0]                  free_idx;
  logic [OCC_W-1:0]                  occ;

  logic                              req_xfer;
  logic                              commit;
  logic                              is_put;
  logic                              cap_zero;
  logic [CMP_W-1:0]                  cap_lim;
  logic                              do_touch;
  logic                              do_ins;
  logic                              do_evict;
  logic                              ins_ok;
  logic [IDX_W-1:0]                  ins_idx;
  logic [COUNT_BITS-1:0]             cnt_inc;

  assign req.ready      = (state == ST_IDLE);
  assign req_xfer       = req.valid && req.ready;
  assign cfg.ready      = 1'b1;

  assign rsp.valid      = rsp_valid;
  assign rsp.found      = rsp_found;
  assign rsp.read_value = rsp_read_value;
  assign rsp.evicted    = rsp_evicted;

  assign scan_ctl.clear = req_xfer;
  assign scan_ctl.step  = s1_step;
  assign scan_ctl.live  = valid_bits[s1_idx];

  lfu_ctbl_store #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk      (clk),
    .rd_idx   (scan_idx),
    .rd_key   (ent_key),
    .rd_data  (ent_data),
    .rd_count (ent_count),
    .rd_rank  (ent_rank),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .wr_key   (key_r),
    .wr_data  (val_r),
    .wr_count (wr_count),
    .wr_rank  (wr_rank)
  );

  lfu_ctbl_scan #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .ctl          (scan_ctl),
    .idx          (s1_idx),
    .search_key   (key_r),
    .ent_key      (ent_key),
    .ent_data     (ent_data),
    .ent_count    (ent_count),
    .ent_rank     (ent_rank),
    .pend_on      (pend_on),
    .pend_all     (pend_all),
    .pend_thresh  (pend_thresh),
    .pend_special (pend_special),
    .wb_en        (wb_en),
    .wb_rank      (wb_rank),
    .hit          (hit),
    .hit_idx      (hit_idx),
    .hit_data     (hit_data),
    .hit_count    (hit_count),
    .hit_rank     (hit_rank),
    .vic_found    (vic_found),
    .vic_idx      (vic_idx),
    .vic_rank     (vic_rank),
    .free_found   (free_found),
    .free_idx     (free_idx),
    .occ          (occ)
  );

  // Decision for the item whose scan has just finished.
  always_comb begin
    commit   = (state == ST_FIN) && (!rsp_valid || rsp.ready);
    is_put   = (op_r == lfu_ctbl_pkg::OP_PUT);
    cap_zero = (capacity == '0);
    cap_lim  = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
    do_touch = hit && (!is_put || !cap_zero);
    do_ins   = is_put && !cap_zero && !hit;
    do_evict = do_ins && vic_found && (CMP_W'(occ) >= cap_lim);
    // The freed victim competes with the first free slot for the lowest index.
    ins_idx  = (do_evict && (!free_found || (vic_idx < free_idx))) ? vic_idx : free_idx;
    ins_ok   = do_ins && (do_evict || free_found);
    cnt_inc  = (hit_count == '1) ? hit_count : hit_count + 1'b1;
  end

  always_comb begin
    valid_next = valid_bits;
    if (do_evict) begin
      valid_next[vic_idx] = 1'b0;
    end
    if (ins_ok) begin
      valid_next[ins_idx] = 1'b1;
    end
  end

  always_comb begin
    wr       = '0;
    wr_idx   = s1_idx;
    wr_count = cnt_inc;
    wr_rank  = wb_rank;
    if (commit && do_touch) begin
      wr.data_we  = is_put;
      wr.count_we = 1'b1;
      wr.rank_we  = 1'b1;
      wr_idx      = hit_idx;
      wr_rank     = '0;
    end else if (commit && ins_ok) begin
      wr.key_we   = 1'b1;
      wr.data_we  = 1'b1;
      wr.count_we = 1'b1;
      wr.rank_we  = 1'b1;
      wr_idx      = ins_idx;
      wr_count    = COUNT_BITS'(1);
      wr_rank     = '0;
    end else if (wb_en) begin
      wr.rank_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      capacity   <= lfu_ctbl_pkg::CAP_RESET;
      s1_step    <= 1'b0;
      valid_bits <= '0;
      pend_on    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.capacity_in_use;
      end
      s1_step <= (state == ST_SCAN);
      // A new response may replace one that is transferred at the same edge.
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (commit) begin
            state      <= ST_IDLE;
            valid_bits <= valid_next;
            // The rank shift for the other entries is applied during the next scan.
            pend_on    <= do_touch || ins_ok;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_r  <= req.operation;
      key_r <= req.key;
      val_r <= req.value;
    end
    if (req_xfer) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
    s1_idx <= scan_idx;
    if (commit) begin
      rsp_found      <= hit;
      rsp_read_value <= (hit && !is_put) ? hit_data : '0;
      rsp_evicted    <= do_evict;
      pend_all       <= ins_ok && !do_evict;
      pend_thresh    <= do_touch ? hit_rank : vic_rank;
      pend_special   <= do_touch ? hit_idx : ins_idx;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_ctbl_checker.sv =====
// Port-level checker for the LFU cache table unit, attached to the top level by bind.
// Uses the assertion macros of lfu_cache_table_unit_assert.svh.
`default_nettype none

`include "lfu_cache_table_unit_assert.svh"

module lfu_ctbl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_found,
  input wire logic [31:0] rsp_read_value,
  input wire logic        rsp_evicted
);

  // A stalled response keeps its payload.
  `LFU_CTBL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, $stable(rsp_found) && $stable(rsp_read_value) && $stable(rsp_evicted), "response changed while stalled")

  // The unit is busy while a request is being scanned.
  `LFU_CTBL_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")

  // The scan still has to run, so no new response appears right after a request transfer.
  `LFU_CTBL_ASSERT_NXT(a_no_quick_rsp, req_valid && req_ready, !$rose(rsp_valid), "response too early")

  // An eviction only follows a miss, and only a hit returns data.
  `LFU_CTBL_ASSERT_IMP(a_rsp_consistent, rsp_valid, !(rsp_evicted && rsp_found) && (rsp_found || (rsp_read_value == 32'd0)), "inconsistent response fields")

endmodule

bind lfu_cache_table_unit lfu_ctbl_checker u_lfu_ctbl_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_found      (rsp.found),
  .rsp_read_value (rsp.read_value),
  .rsp_evicted    (rsp.evicted)
);

`default_nettype wire
